// File: src/pmc_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pmc_pkg
// Shared types and codes of the partition mode controller.
// -----------------------------------------------------------------------------
package pmc_pkg;

   localparam int NUM_PARTS_DEF = 16;

   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 8;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 16;

   // request op codes
   localparam logic [2:0] OP_GET_OWN   = 3'd0;
   localparam logic [2:0] OP_SET_OWN   = 3'd1;
   localparam logic [2:0] OP_GET_OTHER = 3'd2;
   localparam logic [2:0] OP_SET_OTHER = 3'd3;
   localparam logic [2:0] OP_APPLY     = 3'd4;

   // operating modes
   localparam logic [1:0] MODE_IDLE   = 2'd0;
   localparam logic [1:0] MODE_COLD   = 2'd1;
   localparam logic [1:0] MODE_WARM   = 2'd2;
   localparam logic [1:0] MODE_NORMAL = 2'd3;

   // start conditions
   localparam logic [1:0] SC_NORMAL       = 2'd0;
   localparam logic [1:0] SC_PART_RESTART = 2'd2;

   // status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_VALUE    = 3'd1;
   localparam logic [2:0] ST_STATE    = 3'd2;
   localparam logic [2:0] ST_NOFUNC   = 3'd3;
   localparam logic [2:0] ST_ACCESS   = 3'd4;
   localparam logic [2:0] ST_ID       = 3'd5;
   localparam logic [2:0] ST_LIMIT    = 3'd6;
   localparam logic [2:0] ST_DEFERRED = 3'd7;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_PRIV_MASK    = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_RESTART_MASK = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_NUM_USER     = 2'd2;

   localparam logic [4:0] NUM_USER_RESET = 5'd16;

   // one partition table entry; all-zero is the reset entry
   typedef struct packed {
      logic [1:0] start_cond;
      logic [1:0] pend_mode;
      logic       pending;
      logic       warm;
      logic [1:0] mode;
   } part_entry_type;

endpackage

// File: src/partition_mode_controller.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// partition_mode_controller
// Partition mode table with privilege, id and transition checks per request.
// -----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  req_     | in        | tvalid / tready    | op, caller, target, req_mode
//  rsp_     | out       | tvalid / tready    | status, mode_out, start_cond_out, enqueue
//  csr_     | in        | we (no wait)       | addr = register index, wdata
//
//  On accept, the partition entry is read from the table memory into a
//  register; the execute step then checks, writes the entry back and loads
//  the response register. One request is in flight at a time.
//  A stalled response holds the execute step until rsp_tready frees the
//  output register. Reset is synchronous; table entries carry valid bits,
//  so every entry reads as idle right after reset, with no clearing pass.
// -----------------------------------------------------------------------------
module partition_mode_controller
   import pmc_pkg::*;
#(
   parameter int NUM_PARTS = NUM_PARTS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // request: [2:0] op, [6:3] caller, [14:7] target, [17:15] req_mode, rest zero
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // response: [2:0] status, [4:3] mode_out, [6:5] start_cond_out, [7] enqueue
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int IDX_W = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [15:0] priv_mask_ff;
   logic [15:0] restart_mask_ff;
   logic [4:0]  num_user_ff;

   // latched request
   logic [2:0]       op_ff;
   logic [3:0]       caller_ff;
   logic [7:0]       target_ff;
   logic [2:0]       mode_req_ff;
   logic [IDX_W-1:0] addr_ff;

   // table memory
   part_entry_type       part_mem [NUM_PARTS];
   logic [NUM_PARTS-1:0] entry_valid_ff;
   part_entry_type       rd_entry_ff;
   logic                 rd_valid_ff;

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic             req_fire;
   logic [2:0]       in_op;
   logic [7:0]       in_caller_ext;
   logic [7:0]       in_target;
   logic [7:0]       sel_id;
   logic [IDX_W-1:0] rd_addr;

   part_entry_type cur_entry, new_entry;
   logic [2:0]     status;
   logic           enq;
   logic           do_self;
   logic           op_legal;
   logic           caller_ok, priv, target_ok, restart_ok;
   logic [1:0]     m_req;
   logic [1:0]     m_apply;
   logic           ok_like;
   logic           done;
   logic           mem_we;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---- request decode and table read address
   assign in_op         = req_tdata[2:0];
   assign in_caller_ext = {4'b0000, req_tdata[6:3]};
   assign in_target     = req_tdata[14:7];
   assign sel_id        = (in_op == OP_GET_OWN || in_op == OP_SET_OWN) ? in_caller_ext
                                                                        : in_target;
   // out-of-range ids are rejected later; read a harmless entry
   assign rd_addr = (32'(sel_id) < NUM_PARTS) ? sel_id[IDX_W-1:0] : '0;

   // ---- configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         priv_mask_ff    <= '0;
         restart_mask_ff <= '0;
         num_user_ff     <= NUM_USER_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_PRIV_MASK:    priv_mask_ff    <= csr_wdata;
            CSR_RESTART_MASK: restart_mask_ff <= csr_wdata;
            CSR_NUM_USER:     num_user_ff     <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // ---- latched request fields
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff       <= in_op;
         caller_ff   <= req_tdata[6:3];
         target_ff   <= in_target;
         mode_req_ff <= req_tdata[17:15];
         addr_ff     <= rd_addr;
      end
   end

   // ---- table memory: registered read, write back from the execute step.
   // The write lands on an earlier edge than the next read, so no bypass.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         part_mem[addr_ff] <= new_entry;
      end
      if (req_fire) begin
         rd_entry_ff <= part_mem[rd_addr];
         rd_valid_ff <= entry_valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
      end else if (mem_we) begin
         entry_valid_ff[addr_ff] <= 1'b1;
      end
   end

   // ---- execute: checks and entry update
   always_comb begin
      cur_entry  = rd_valid_ff ? rd_entry_ff : '0;
      new_entry  = cur_entry;
      status     = ST_NOFUNC;
      enq        = 1'b0;
      do_self    = 1'b0;
      op_legal   = 1'b1;
      m_req      = mode_req_ff[1:0];
      m_apply    = cur_entry.pend_mode;
      caller_ok  = 32'(caller_ff) < NUM_PARTS;
      priv       = priv_mask_ff[caller_ff];
      target_ok  = ({3'b000, num_user_ff} > target_ff) && (32'(target_ff) < NUM_PARTS);
      restart_ok = (target_ff < 8'd16) && restart_mask_ff[target_ff[3:0]];

      case (op_ff)
         OP_GET_OWN: begin
            status = ST_OK;
         end
         OP_SET_OWN: begin
            if (mode_req_ff > {1'b0, MODE_NORMAL}) status = ST_VALUE;
            else do_self = 1'b1;
         end
         OP_GET_OTHER: begin
            if (!priv) status = ST_ACCESS;
            else if (!target_ok) status = ST_ID;
            else status = ST_OK;
         end
         OP_SET_OTHER: begin
            if (!priv) status = ST_ACCESS;
            else if (mode_req_ff > {1'b0, MODE_NORMAL}) status = ST_VALUE;
            else if (!target_ok) status = ST_ID;
            else if (!restart_ok) status = ST_LIMIT;
            else if (target_ff == {4'b0000, caller_ff}) do_self = 1'b1;
            else if (m_req == MODE_NORMAL) status = ST_STATE;
            else if (m_req == MODE_WARM && !cur_entry.warm) status = ST_STATE;
            else begin
               status = ST_OK;
               if (!cur_entry.pending) begin
                  new_entry.pending   = 1'b1;
                  new_entry.pend_mode = m_req;
                  enq                 = 1'b1;
               end
            end
         end
         OP_APPLY: begin
            if (!target_ok) status = ST_ID;
            else if (!cur_entry.pending) status = ST_STATE;
            else begin
               status = ST_OK;
               if (m_apply == MODE_NORMAL) m_apply = MODE_IDLE;
               if (m_apply == MODE_WARM && !cur_entry.warm) m_apply = MODE_COLD;
               if (m_apply == MODE_COLD) new_entry.warm = 1'b0;
               new_entry.pending    = 1'b0;
               new_entry.mode       = m_apply;
               new_entry.start_cond = SC_PART_RESTART;
            end
         end
         default: begin
            op_legal = 1'b0;
            status   = ST_NOFUNC;
         end
      endcase

      // own-mode change, shared by set own and set other aimed at the caller
      if (do_self) begin
         if (cur_entry.mode == MODE_IDLE || (cur_entry.mode == MODE_COLD && m_req == MODE_WARM)) begin
            status = ST_STATE;
         end else if (m_req == MODE_NORMAL) begin
            if (cur_entry.mode == MODE_NORMAL) begin
               status = ST_NOFUNC;
            end else begin
               status         = ST_OK;
               new_entry.mode = MODE_NORMAL;
               new_entry.warm = 1'b1;
            end
         end else begin
            status = ST_DEFERRED;
            if (!cur_entry.pending) begin
               new_entry.pending   = 1'b1;
               new_entry.pend_mode = m_req;
               enq                 = 1'b1;
            end
         end
      end

      if (op_legal && !caller_ok) begin
         status    = ST_ACCESS;
         new_entry = cur_entry;
         enq       = 1'b0;
      end
   end

   assign ok_like = (status == ST_OK) || (status == ST_DEFERRED);
   assign done    = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_tready);
   assign mem_we  = done && ok_like;

   // ---- control and response register
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (done) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_data_in  = ok_like ? {enq, new_entry.start_cond, new_entry.mode, status}
                                      : {5'b00000, status};
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   // ---- assertions
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !(rsp_data_ff[2:0] == ST_OK || rsp_data_ff[2:0] == ST_DEFERRED)
      |-> rsp_data_ff[7:3] == 5'b00000)
      else $error("error response carries payload");

   a_enq_fresh: assert property (@(posedge clock) disable iff (reset)
      mem_we && enq |-> !cur_entry.pending && new_entry.pending)
      else $error("enqueue without a newly latched change");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("second request taken while one is executing");

   a_wr_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> 32'(addr_ff) < NUM_PARTS)
      else $error("table write beyond partition count");

   a_exec_resp: assert property (@(posedge clock) disable iff (reset)
      done |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("execute step finished without a response");

endmodule
